// File: src/exp_adsr_envelope_macros.svh
// ----------------------------------------------------------------------------
// exp_adsr_envelope_macros.svh
// Assertion helpers for the envelope block. Expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef EXP_ADSR_ENVELOPE_MACROS_SVH
`define EXP_ADSR_ENVELOPE_MACROS_SVH

// same-cycle implication, held off during reset
`define ADSR_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ADSR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, codes and defaults for the exponential ADSR envelope.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int DEF_FRAC_BITS  = 24;
  localparam int DEF_DELAY_BITS = 20;
  localparam int CFG_IDX_W      = 3;

  // reset values of the shape/sustain registers, given with 24 fraction bits
  localparam int           REF_FRAC            = 24;
  localparam longint unsigned ATK_SHAPE_RST_Q24 = 64'd5033165;
  localparam longint unsigned REL_SHAPE_RST_Q24 = 64'd1678;
  localparam longint unsigned SUSTAIN_RST_Q24   = 64'd9227469;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_COEF   = 3'd0,
    CFG_ATTACK_SHAPE  = 3'd1,
    CFG_DECAY_COEF    = 3'd2,
    CFG_RELEASE_COEF  = 3'd3,
    CFG_RELEASE_SHAPE = 3'd4,
    CFG_SUSTAIN_LEVEL = 3'd5,
    CFG_DELAY_TICKS   = 3'd6,
    CFG_MODE          = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic instant;  // bit1: skip attack, start decay at full scale
    logic loop;     // bit0: retrigger from sustain
  } mode_t;

  // envelope stage, one-hot
  typedef enum logic [5:0] {
    ST_OFF     = 6'b000001,
    ST_DELAY   = 6'b000010,
    ST_ATTACK  = 6'b000100,
    ST_DECAY   = 6'b001000,
    ST_SUSTAIN = 6'b010000,
    ST_RELEASE = 6'b100000
  } stage_t;

  // external stage codes
  localparam logic [2:0] CODE_OFF     = 3'd0;
  localparam logic [2:0] CODE_DELAY   = 3'd1;
  localparam logic [2:0] CODE_ATTACK  = 3'd2;
  localparam logic [2:0] CODE_DECAY   = 3'd3;
  localparam logic [2:0] CODE_SUSTAIN = 3'd4;
  localparam logic [2:0] CODE_RELEASE = 3'd5;

  function automatic logic [2:0] stage_code(stage_t s);
    logic [2:0] c;
    unique case (s)
      ST_OFF:     c = CODE_OFF;
      ST_DELAY:   c = CODE_DELAY;
      ST_ATTACK:  c = CODE_ATTACK;
      ST_DECAY:   c = CODE_DECAY;
      ST_SUSTAIN: c = CODE_SUSTAIN;
      ST_RELEASE: c = CODE_RELEASE;
      default:    c = CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

// File: src/exp_adsr_envelope.sv
// ----------------------------------------------------------------------------
// exp_adsr_envelope
// Exponential ADSR envelope generator with optional delay stage.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / in_gate): one item per sample tick,
//    carrying the gate level. Output channel (out_valid / out_stall /
//    out_envelope / out_stage_now): one item per input item, the level and
//    stage after that tick.
//  - Config port: cfg_we with cfg_index and cfg_wdata writes one register in
//    the clock edge; write only while no item is in flight.
//  - Path: an accepted item passes the input register, then the update into
//    the output register, where out_valid rises; a receiver stall can hold
//    the item in the input register.
//  - Throughput: 1 item per cycle while out_stall is low, set by the level
//    update loop (one multiply-add and clamp from the state register back to itself).
//  - Reset (rst_n low, synchronous): pipeline empty, stage off, level zero,
//    registers at their default values; in_stall is high during reset.
//  - Receiver stall: the output register holds; the input register still
//    takes one item, after which in_stall rises until out_stall drops.
// ----------------------------------------------------------------------------
module exp_adsr_envelope #(
  parameter int FRAC_BITS  = adsr_pkg::DEF_FRAC_BITS,
  parameter int DELAY_BITS = adsr_pkg::DEF_DELAY_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_gate,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [FRAC_BITS:0]             out_envelope,
  output logic [2:0]                     out_stage_now,
  // config write port
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [((FRAC_BITS + 3 > DELAY_BITS) ? FRAC_BITS + 3 : DELAY_BITS)-1:0] cfg_wdata
);
  import adsr_pkg::*;

  localparam int CFG_W = (FRAC_BITS + 3 > DELAY_BITS) ? FRAC_BITS + 3 : DELAY_BITS;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // config operands
  logic [FRAC_BITS-1:0]  attack_coef, decay_coef, release_coef;
  logic [FRAC_BITS+3:0]  attack_base;
  logic [FRAC_BITS+2:0]  release_shape;
  logic [FRAC_BITS:0]    sustain;
  logic [DELAY_BITS-1:0] delay_ticks;
  mode_t                 mode;

  adsr_cfg #(
    .FRAC_BITS  (FRAC_BITS),
    .DELAY_BITS (DELAY_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .attack_coef   (attack_coef),
    .attack_base   (attack_base),
    .decay_coef    (decay_coef),
    .release_coef  (release_coef),
    .release_shape (release_shape),
    .sustain       (sustain),
    .delay_ticks   (delay_ticks),
    .mode          (mode)
  );

  // pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic s1_gate_r;
  logic out_valid_r, out_valid_nxt;
  logic advance, step_en;

  // output slot free or being drained this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !rst_n || (s1_valid_r && !advance);
  assign step_en  = s1_valid_r && advance;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_gate_r <= in_gate;
    end
  end

  // envelope update; state advances only when the result is captured
  logic [FRAC_BITS:0] level_nxt;
  logic [2:0]         stage_nxt;

  adsr_core #(
    .FRAC_BITS  (FRAC_BITS),
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .gate          (s1_gate_r),
    .attack_coef   (attack_coef),
    .attack_base   (attack_base),
    .decay_coef    (decay_coef),
    .release_coef  (release_coef),
    .release_shape (release_shape),
    .sustain       (sustain),
    .delay_ticks   (delay_ticks),
    .mode          (mode),
    .level_nxt     (level_nxt),
    .stage_nxt     (stage_nxt)
  );

  // result register
  logic [FRAC_BITS:0] out_envelope_r;
  logic [2:0]         out_stage_r;

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_envelope_r <= level_nxt;
      out_stage_r    <= stage_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_envelope  = out_envelope_r;
  assign out_stage_now = out_stage_r;

  // checks
`include "exp_adsr_envelope_macros.svh"

  `ADSR_CHECK(a_off_is_zero, out_valid && (out_stage_now == CODE_OFF), out_envelope == '0, "off with level")
  `ADSR_CHECK(a_level_in_range, out_valid, out_envelope <= ONE, "envelope above full scale")
  `ADSR_CHECK(a_stall_only_when_full, rst_n && in_stall, out_valid && out_stall, "stall, slot free")
  `ADSR_CHECK_NEXT(a_step_gives_result, step_en, out_valid, "computed item not presented")

endmodule

// File: src/adsr_cfg.sv
// ----------------------------------------------------------------------------
// adsr_cfg
// Configuration register file with derived operands (nonzero shapes,
// attack target, saturated sustain).
// ----------------------------------------------------------------------------
module adsr_cfg #(
  parameter int FRAC_BITS  = adsr_pkg::DEF_FRAC_BITS,
  parameter int DELAY_BITS = adsr_pkg::DEF_DELAY_BITS,
  parameter int CFG_W      = FRAC_BITS + 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  output logic [FRAC_BITS-1:0]           attack_coef,
  output logic [FRAC_BITS+3:0]           attack_base,
  output logic [FRAC_BITS-1:0]           decay_coef,
  output logic [FRAC_BITS-1:0]           release_coef,
  output logic [FRAC_BITS+2:0]           release_shape,
  output logic [FRAC_BITS:0]             sustain,
  output logic [DELAY_BITS-1:0]          delay_ticks,
  output adsr_pkg::mode_t                mode
);
  import adsr_pkg::*;

  localparam int SHP_W = FRAC_BITS + 3;
  localparam int LVL_W = FRAC_BITS + 1;
  localparam logic [LVL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam longint unsigned ATK_SHAPE_RST = (ATK_SHAPE_RST_Q24 << FRAC_BITS) >> REF_FRAC;
  localparam longint unsigned REL_SHAPE_RST = (REL_SHAPE_RST_Q24 << FRAC_BITS) >> REF_FRAC;
  localparam longint unsigned SUSTAIN_RST   = (SUSTAIN_RST_Q24 << FRAC_BITS) >> REF_FRAC;

  logic [FRAC_BITS-1:0]  attack_coef_r, decay_coef_r, release_coef_r;
  logic [SHP_W-1:0]      attack_shape_r, release_shape_r;
  logic [LVL_W-1:0]      sustain_r;
  logic [DELAY_BITS-1:0] delay_ticks_r;
  mode_t                 mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_coef_r   <= '0;
      attack_shape_r  <= SHP_W'(ATK_SHAPE_RST);
      decay_coef_r    <= '0;
      release_coef_r  <= '0;
      release_shape_r <= SHP_W'(REL_SHAPE_RST);
      sustain_r       <= LVL_W'(SUSTAIN_RST);
      delay_ticks_r   <= '0;
      mode_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ATTACK_COEF:   attack_coef_r   <= cfg_wdata[FRAC_BITS-1:0];
        CFG_ATTACK_SHAPE:  attack_shape_r  <= cfg_wdata[SHP_W-1:0];
        CFG_DECAY_COEF:    decay_coef_r    <= cfg_wdata[FRAC_BITS-1:0];
        CFG_RELEASE_COEF:  release_coef_r  <= cfg_wdata[FRAC_BITS-1:0];
        CFG_RELEASE_SHAPE: release_shape_r <= cfg_wdata[SHP_W-1:0];
        CFG_SUSTAIN_LEVEL: sustain_r       <= cfg_wdata[LVL_W-1:0];
        CFG_DELAY_TICKS:   delay_ticks_r   <= cfg_wdata[DELAY_BITS-1:0];
        CFG_MODE:          mode_r          <= mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  logic [SHP_W-1:0] attack_shape_nz;

  // a zero shape acts as the smallest ratio
  assign attack_shape_nz = (attack_shape_r == '0) ? SHP_W'(1) : attack_shape_r;
  assign release_shape   = (release_shape_r == '0) ? SHP_W'(1) : release_shape_r;
  assign attack_base     = (SHP_W + 1)'(ONE) + (SHP_W + 1)'(attack_shape_nz);
  assign sustain         = (sustain_r > ONE) ? ONE : sustain_r;

  assign attack_coef  = attack_coef_r;
  assign decay_coef   = decay_coef_r;
  assign release_coef = release_coef_r;
  assign delay_ticks  = delay_ticks_r;
  assign mode         = mode_r;

endmodule

// File: src/adsr_core.sv
// ----------------------------------------------------------------------------
// adsr_core
// Envelope state and the per-tick update: gate edge handling, delay count,
// and one multiply-add recursion level' = base + (level - base) * coef.
// ----------------------------------------------------------------------------
module adsr_core #(
  parameter int FRAC_BITS  = adsr_pkg::DEF_FRAC_BITS,
  parameter int DELAY_BITS = adsr_pkg::DEF_DELAY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  gate,
  input  logic [FRAC_BITS-1:0]  attack_coef,
  input  logic [FRAC_BITS+3:0]  attack_base,
  input  logic [FRAC_BITS-1:0]  decay_coef,
  input  logic [FRAC_BITS-1:0]  release_coef,
  input  logic [FRAC_BITS+2:0]  release_shape,
  input  logic [FRAC_BITS:0]    sustain,
  input  logic [DELAY_BITS-1:0] delay_ticks,
  input  adsr_pkg::mode_t       mode,
  output logic [FRAC_BITS:0]    level_nxt,
  output logic [2:0]            stage_nxt
);
  import adsr_pkg::*;

  localparam int LVL_W  = FRAC_BITS + 1;
  localparam int BASE_W = FRAC_BITS + 5;
  localparam int DIFF_W = FRAC_BITS + 6;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int V_W    = SUM_W - FRAC_BITS;

  localparam logic [LVL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LVL_W-1:0] SMALL_LEVEL =
    LVL_W'((64'd1 << FRAC_BITS) / 64'd1000000);
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

  // state
  logic [LVL_W-1:0]      level_r;
  stage_t                stage_r;
  logic [DELAY_BITS-1:0] count_r;
  logic                  last_gate_r;

  logic                  delay_zero, rise, fall;
  stage_t                stage_a, stage_n;
  logic [LVL_W-1:0]      level_a, level_n;
  logic [DELAY_BITS-1:0] count_a, count_n;

  assign delay_zero = (delay_ticks == '0);
  assign rise       = !last_gate_r && gate;
  assign fall       = last_gate_r && !gate;

  // gate edges first
  always_comb begin
    stage_a = stage_r;
    level_a = level_r;
    count_a = count_r;
    if (rise) begin
      if (delay_zero) begin
        if (mode.instant) begin
          stage_a = ST_DECAY;
          level_a = ONE;
        end else begin
          stage_a = ST_ATTACK;
        end
      end else begin
        if (level_r <= SMALL_LEVEL) begin
          level_a = '0;
          count_a = '0;
        end
        stage_a = ST_DELAY;
      end
    end else if (fall) begin
      stage_a = ST_RELEASE;
    end
  end

  // recursion operands for the stage after the edge
  logic signed [BASE_W-1:0] base;
  logic        [FRAC_BITS-1:0] coef;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [V_W-1:0]    v, one_v, sus_v;

  always_comb begin
    unique case (stage_a)
      ST_ATTACK: begin
        base = signed'({1'b0, attack_base});
        coef = attack_coef;
      end
      ST_DECAY: begin
        base = signed'({4'b0, sustain}) - signed'({2'b0, release_shape});
        coef = decay_coef;
      end
      default: begin
        base = -signed'({2'b0, release_shape});
        coef = release_coef;
      end
    endcase
  end

  assign diff  = signed'({5'b0, level_a}) - DIFF_W'(base);
  assign prod  = PROD_W'(diff) * PROD_W'(signed'({1'b0, coef}));
  // floor of the scaled sum: arithmetic shift
  assign sum   = SUM_W'(prod) + (SUM_W'(base) <<< FRAC_BITS);
  assign v     = V_W'(sum >>> FRAC_BITS);
  assign one_v = signed'(V_W'(ONE));
  assign sus_v = signed'(V_W'(sustain));

  always_comb begin
    logic [DELAY_BITS-1:0] count_inc;
    count_inc = (count_a == DELAY_MAX) ? count_a : count_a + DELAY_BITS'(1);
    stage_n   = stage_a;
    level_n   = level_a;
    count_n   = count_a;
    unique case (stage_a)
      ST_DELAY: begin
        count_n = count_inc;
        if (count_inc >= delay_ticks) begin
          count_n = '0;
          if (mode.instant) begin
            stage_n = ST_DECAY;
            level_n = ONE;
          end else begin
            stage_n = ST_ATTACK;
          end
        end
      end
      ST_ATTACK: begin
        if (v >= one_v) begin
          level_n = ONE;
          stage_n = ST_DECAY;
        end else begin
          level_n = v[LVL_W-1:0];
        end
      end
      ST_DECAY: begin
        if (v <= sus_v) begin
          level_n = sustain;
          stage_n = ST_SUSTAIN;
        end else begin
          level_n = v[LVL_W-1:0];
        end
      end
      ST_SUSTAIN: begin
        level_n = sustain;
        if (mode.loop) begin
          // retrigger with the sustain level as current level
          if (delay_zero) begin
            if (mode.instant) begin
              stage_n = ST_DECAY;
              level_n = ONE;
            end else begin
              stage_n = ST_ATTACK;
            end
          end else begin
            if (sustain <= SMALL_LEVEL) begin
              level_n = '0;
              count_n = '0;
            end
            stage_n = ST_DELAY;
          end
        end
      end
      ST_RELEASE: begin
        if (v[V_W-1] || (v == '0)) begin
          level_n = '0;
          stage_n = ST_OFF;
        end else begin
          level_n = v[LVL_W-1:0];
        end
      end
      default: begin
        level_n = '0;
        stage_n = ST_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      stage_r     <= ST_OFF;
      count_r     <= '0;
      last_gate_r <= 1'b0;
    end else if (step_en) begin
      level_r     <= level_n;
      stage_r     <= stage_n;
      count_r     <= count_n;
      last_gate_r <= gate;
    end
  end

  assign level_nxt = level_n;
  assign stage_nxt = stage_code(stage_n);

endmodule
